FILE: rtl/vde_pkg.sv
package vde_pkg;

    // Default widths of the sample and timestamp fields.
    localparam int DEFAULT_SAMPLE_BITS = 10;
    localparam int DEFAULT_TIME_BITS   = 32;

    // Vehicle sequence states.
    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_BUZZ  = 2'd2;
    localparam logic [1:0] MODE_DRIVE = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 29;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRAKE_PRESS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRAKE_LAMP   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MISMATCH_LIM = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MISMATCH_TMO = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUZZ_DUR     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_READY_ID     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_READY_BYTE   = 3'd7;

    // Configuration reset values.
    localparam logic [9:0]  RST_BRAKE_PRESS  = 10'd600;
    localparam logic [9:0]  RST_BRAKE_LAMP   = 10'd102;
    localparam logic [9:0]  RST_MISMATCH_LIM = 10'd102;
    localparam logic [15:0] RST_MISMATCH_TMO = 16'd100;
    localparam logic [15:0] RST_BUZZ_DUR     = 16'd2000;
    localparam logic [28:0] RST_READY_ID     = 29'h186040F3;
    localparam logic [7:0]  RST_READY_BYTE   = 8'h50;

    // Fixed field widths.
    localparam int FRAME_ID_W  = 29;
    localparam int FRAME_LEN_W = 4;
    localparam int FRAME_BYTE_W = 8;
    localparam int TORQUE_W    = 16;
    localparam int DIFF_OUT_W  = 12;
    localparam logic [FRAME_LEN_W-1:0] READY_MIN_LEN = 4'd7;

    // Low pedal channel rescale ratio (5 V range over 3.3 V range).
    localparam longint SCALE_NUM = 1023;
    localparam longint SCALE_DEN = 675;

    // Torque is the high pedal sample times 32, clipped to the positive range.
    localparam int TORQUE_SHIFT = 5;
    localparam logic [TORQUE_W-1:0] TORQUE_MAX = 16'h7FFF;

    // Saturation limits of the reported difference.
    localparam int DIFF_OUT_MAX = 2047;
    localparam int DIFF_OUT_MIN = -2048;

    // Result tdata: state, brake light, drive lamp, buzzer, torque, fault, diff.
    localparam int OUT_BITS    = 2 + 1 + 1 + 1 + TORQUE_W + 1 + DIFF_OUT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

FILE: rtl/vehicle_drive_enable_fsm_unit.sv
// A tick passes the input register, the rescale register and the result register.
// Throughput: one tick per cycle unless the master side stalls; a pedal rescale
// multiply stage feeds the sequence update stage, which updates its state per tick.
// Reset (i_rst_n low, synchronous) empties the pipeline, returns the sequence to init,
// clears the mismatch record and lamps, and loads the configuration defaults.
module vehicle_drive_enable_fsm_unit #(
    parameter int SAMPLE_BITS = vde_pkg::DEFAULT_SAMPLE_BITS,
    parameter int TIME_BITS   = vde_pkg::DEFAULT_TIME_BITS,
    parameter int IN_TDATA_W  = ((TIME_BITS + 3 * SAMPLE_BITS + 42 + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave side. tdata from bit 0: now_ms, brake_sample, pedal_high_sample,
    // pedal_low_sample, start_pressed, frame_id, frame_length, frame_byte_six.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [IN_TDATA_W-1:0]              i_s_tdata,
    // tuser: frame_present.
    input  logic                               i_s_tuser,
    // Master side. tdata from bit 0: vehicle_state, brake_light, drive_lamp,
    // buzzer_on, torque_cmd, fault_reported, diff_reported.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [vde_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // tuser: torque_sent.
    output logic                               o_m_tuser,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vde_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [vde_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import vde_pkg::*;

    // Input field offsets inside tdata.
    localparam int OFS_NOW   = 0;
    localparam int OFS_BRAKE = OFS_NOW + TIME_BITS;
    localparam int OFS_HIGH  = OFS_BRAKE + SAMPLE_BITS;
    localparam int OFS_LOW   = OFS_HIGH + SAMPLE_BITS;
    localparam int OFS_START = OFS_LOW + SAMPLE_BITS;
    localparam int OFS_FID   = OFS_START + 1;
    localparam int OFS_FLEN  = OFS_FID + FRAME_ID_W;
    localparam int OFS_FBYTE = OFS_FLEN + FRAME_LEN_W;

    // Threshold registers are 10 bits wide; samples are compared against them
    // at the wider of the two widths so that neither side is cut.
    localparam int LEVEL_W = 10;
    localparam int CMP_W   = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    // Rescale: floor(low * 1023 / 675) as one multiply by a rounded-up reciprocal.
    // With REC_SH = SAMPLE_BITS + 10 the rounding error stays below 1/675 per
    // sample, so the quotient is exact over the whole sample range.
    localparam int     REC_SH = SAMPLE_BITS + 10;
    localparam longint REC_M_FULL = ((SCALE_NUM << REC_SH) + SCALE_DEN - 1) / SCALE_DEN;
    localparam int     REC_MW = REC_SH + 2;
    localparam logic [REC_MW-1:0] REC_M = REC_MW'(REC_M_FULL);
    localparam int     PROD_W = SAMPLE_BITS + REC_MW;
    localparam int     SCALED_W = SAMPLE_BITS + 1;
    localparam int     DIFF_W = CMP_W + 2;
    localparam int     TQ_W = SAMPLE_BITS + TORQUE_SHIFT;

    localparam logic signed [DIFF_W-1:0] DIFF_HI = DIFF_W'(DIFF_OUT_MAX);
    localparam logic signed [DIFF_W-1:0] DIFF_LO = DIFF_W'(DIFF_OUT_MIN);

    // Configuration registers.
    logic [9:0]            r_brake_press_level;
    logic [9:0]            r_brake_lamp_level;
    logic [9:0]            r_pedal_mismatch_limit;
    logic [15:0]           r_mismatch_timeout_ms;
    logic [15:0]           r_buzz_duration_ms;
    logic                  r_reverse_torque;
    logic [FRAME_ID_W-1:0] r_ready_frame_id;
    logic [7:0]            r_ready_byte_value;

    assign o_cfg_ready = 1'b1;

    // Register writes on each configuration transfer; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brake_press_level    <= RST_BRAKE_PRESS;
            r_brake_lamp_level     <= RST_BRAKE_LAMP;
            r_pedal_mismatch_limit <= RST_MISMATCH_LIM;
            r_mismatch_timeout_ms  <= RST_MISMATCH_TMO;
            r_buzz_duration_ms     <= RST_BUZZ_DUR;
            r_reverse_torque       <= 1'b0;
            r_ready_frame_id       <= RST_READY_ID;
            r_ready_byte_value     <= RST_READY_BYTE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BRAKE_PRESS:  r_brake_press_level    <= i_cfg_data[9:0];
                CFG_BRAKE_LAMP:   r_brake_lamp_level     <= i_cfg_data[9:0];
                CFG_MISMATCH_LIM: r_pedal_mismatch_limit <= i_cfg_data[9:0];
                CFG_MISMATCH_TMO: r_mismatch_timeout_ms  <= i_cfg_data[15:0];
                CFG_BUZZ_DUR:     r_buzz_duration_ms     <= i_cfg_data[15:0];
                CFG_REVERSE:      r_reverse_torque       <= i_cfg_data[0];
                CFG_READY_ID:     r_ready_frame_id       <= i_cfg_data[FRAME_ID_W-1:0];
                CFG_READY_BYTE:   r_ready_byte_value     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake: each stage loads when it is empty or the next one moves.
    logic r_s0_valid;
    logic r_s1_valid;
    logic r_out_valid;
    logic out_ready;
    logic s1_ready;
    logic s0_ready;

    assign out_ready  = !r_out_valid || i_m_tready;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign s0_ready   = !r_s0_valid || s1_ready;
    assign o_s_tready = s0_ready;

    // Stage 0: input register.
    logic [TIME_BITS-1:0]    r_s0_now;
    logic [SAMPLE_BITS-1:0]  r_s0_brake;
    logic [SAMPLE_BITS-1:0]  r_s0_high;
    logic [SAMPLE_BITS-1:0]  r_s0_low;
    logic                    r_s0_start;
    logic                    r_s0_present;
    logic [FRAME_ID_W-1:0]   r_s0_fid;
    logic [FRAME_LEN_W-1:0]  r_s0_flen;
    logic [FRAME_BYTE_W-1:0] r_s0_fbyte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready && i_s_tvalid) begin
            r_s0_now     <= i_s_tdata[OFS_NOW +: TIME_BITS];
            r_s0_brake   <= i_s_tdata[OFS_BRAKE +: SAMPLE_BITS];
            r_s0_high    <= i_s_tdata[OFS_HIGH +: SAMPLE_BITS];
            r_s0_low     <= i_s_tdata[OFS_LOW +: SAMPLE_BITS];
            r_s0_start   <= i_s_tdata[OFS_START];
            r_s0_present <= i_s_tuser;
            r_s0_fid     <= i_s_tdata[OFS_FID +: FRAME_ID_W];
            r_s0_flen    <= i_s_tdata[OFS_FLEN +: FRAME_LEN_W];
            r_s0_fbyte   <= i_s_tdata[OFS_FBYTE +: FRAME_BYTE_W];
        end
    end

    // Rescale multiply of the low pedal channel.
    logic [PROD_W-1:0]   scale_prod;
    logic [SCALED_W-1:0] scale_q;

    assign scale_prod = PROD_W'(r_s0_low) * PROD_W'(REC_M);
    assign scale_q    = SCALED_W'(scale_prod >> REC_SH);

    // Stage 1: rescaled sample and the fields carried along.
    logic [TIME_BITS-1:0]    r_s1_now;
    logic [SAMPLE_BITS-1:0]  r_s1_brake;
    logic [SAMPLE_BITS-1:0]  r_s1_high;
    logic [SCALED_W-1:0]     r_s1_scaled;
    logic                    r_s1_start;
    logic                    r_s1_present;
    logic [FRAME_ID_W-1:0]   r_s1_fid;
    logic [FRAME_LEN_W-1:0]  r_s1_flen;
    logic [FRAME_BYTE_W-1:0] r_s1_fbyte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && r_s0_valid) begin
            r_s1_now     <= r_s0_now;
            r_s1_brake   <= r_s0_brake;
            r_s1_high    <= r_s0_high;
            r_s1_scaled  <= scale_q;
            r_s1_start   <= r_s0_start;
            r_s1_present <= r_s0_present;
            r_s1_fid     <= r_s0_fid;
            r_s1_flen    <= r_s0_flen;
            r_s1_fbyte   <= r_s0_fbyte;
        end
    end

    // Sequence state.
    logic [1:0]                   r_mode;
    logic [TIME_BITS-1:0]         r_mode_entry_time;
    logic                         r_mismatch_flag;
    logic [TIME_BITS-1:0]         r_mismatch_start_time;
    logic signed [DIFF_OUT_W-1:0] r_last_difference;
    logic                         r_drive_lamp_level;
    logic                         r_buzzer_level;

    logic [1:0]                   n_mode;
    logic [TIME_BITS-1:0]         n_mode_entry_time;
    logic                         n_mismatch_flag;
    logic [TIME_BITS-1:0]         n_mismatch_start_time;
    logic signed [DIFF_OUT_W-1:0] n_last_difference;
    logic                         n_drive_lamp_level;
    logic                         n_buzzer_level;

    // Per-tick decodes.
    logic                         fire;
    logic                         brake_pressed;
    logic                         brake_light;
    logic                         frame_ready;
    logic [TIME_BITS-1:0]         mode_elapsed;
    logic [TIME_BITS-1:0]         mismatch_elapsed;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [DIFF_W-1:0]     lim_pos;
    logic signed [DIFF_W-1:0]     lim_neg;
    logic                         implausible;
    logic signed [DIFF_OUT_W-1:0] diff_sat;
    logic [TQ_W-1:0]              torque_raw;
    logic [TORQUE_W-1:0]          torque_mag;
    logic [TORQUE_W-1:0]          torque_val;
    logic                         sent;
    logic [TORQUE_W-1:0]          cmd;

    assign fire          = r_s1_valid && out_ready;
    assign brake_pressed = CMP_W'(r_s1_brake) >= CMP_W'(r_brake_press_level);
    assign brake_light   = CMP_W'(r_s1_brake) >= CMP_W'(r_brake_lamp_level);
    assign frame_ready   = r_s1_present && (r_s1_fid == r_ready_frame_id)
                           && (r_s1_flen >= READY_MIN_LEN)
                           && (r_s1_fbyte == r_ready_byte_value);
    assign mode_elapsed     = r_s1_now - r_mode_entry_time;
    assign mismatch_elapsed = r_s1_now - r_mismatch_start_time;

    // Pedal plausibility: exact difference against the symmetric limit.
    assign diff    = $signed(DIFF_W'(r_s1_high)) - $signed(DIFF_W'(r_s1_scaled));
    assign lim_pos = $signed(DIFF_W'(r_pedal_mismatch_limit));
    assign lim_neg = -lim_pos;
    assign implausible = (diff > lim_pos) || (diff < lim_neg);

    always_comb begin
        if (diff > DIFF_HI) begin
            diff_sat = DIFF_OUT_W'(DIFF_HI);
        end else if (diff < DIFF_LO) begin
            diff_sat = DIFF_OUT_W'(DIFF_LO);
        end else begin
            diff_sat = DIFF_OUT_W'(diff);
        end
    end

    // Torque command from the high pedal sample.
    assign torque_raw = TQ_W'(r_s1_high) << TORQUE_SHIFT;
    assign torque_mag = (torque_raw > TQ_W'(TORQUE_MAX)) ? TORQUE_MAX
                                                         : TORQUE_W'(torque_raw);
    assign torque_val = r_reverse_torque ? (~torque_mag + 1'b1) : torque_mag;

    // Sequence step.
    always_comb begin
        n_mode                = r_mode;
        n_mode_entry_time     = r_mode_entry_time;
        n_mismatch_flag       = r_mismatch_flag;
        n_mismatch_start_time = r_mismatch_start_time;
        n_last_difference     = r_last_difference;
        n_drive_lamp_level    = r_drive_lamp_level;
        n_buzzer_level        = r_buzzer_level;
        sent                  = 1'b1;
        cmd                   = '0;
        case (r_mode)
            MODE_INIT: begin
                n_drive_lamp_level = 1'b0;
                n_buzzer_level     = 1'b0;
                if (r_s1_start && brake_pressed) begin
                    n_mode            = MODE_START;
                    n_mode_entry_time = r_s1_now;
                end
            end
            MODE_START: begin
                if (!r_s1_start || !brake_pressed) begin
                    n_mode            = MODE_INIT;
                    n_mode_entry_time = r_s1_now;
                end else if (frame_ready) begin
                    n_mode            = MODE_BUZZ;
                    n_mode_entry_time = r_s1_now;
                end
            end
            MODE_BUZZ: begin
                n_buzzer_level = 1'b1;
                if (mode_elapsed >= TIME_BITS'(r_buzz_duration_ms)) begin
                    n_buzzer_level     = 1'b0;
                    n_mode             = MODE_DRIVE;
                    n_mode_entry_time  = r_s1_now;
                    n_drive_lamp_level = 1'b1;
                end
            end
            MODE_DRIVE: begin
                n_drive_lamp_level = 1'b1;
                n_last_difference  = diff_sat;
                if (implausible) begin
                    if (!r_mismatch_flag) begin
                        // First disagreeing tick: start the timer, hold the command.
                        n_mismatch_flag       = 1'b1;
                        n_mismatch_start_time = r_s1_now;
                        sent                  = 1'b0;
                    end else if (mismatch_elapsed >= TIME_BITS'(r_mismatch_timeout_ms)) begin
                        // Disagreement outlasted the timeout: zero torque, back to init.
                        n_drive_lamp_level = 1'b0;
                        n_mode             = MODE_INIT;
                        n_mode_entry_time  = r_s1_now;
                    end else begin
                        cmd = torque_val;
                    end
                end else begin
                    n_mismatch_flag = 1'b0;
                    cmd             = torque_val;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode                <= MODE_INIT;
            r_mode_entry_time     <= '0;
            r_mismatch_flag       <= 1'b0;
            r_mismatch_start_time <= '0;
            r_last_difference     <= '0;
            r_drive_lamp_level    <= 1'b0;
            r_buzzer_level        <= 1'b0;
        end else if (fire) begin
            r_mode                <= n_mode;
            r_mode_entry_time     <= n_mode_entry_time;
            r_mismatch_flag       <= n_mismatch_flag;
            r_mismatch_start_time <= n_mismatch_start_time;
            r_last_difference     <= n_last_difference;
            r_drive_lamp_level    <= n_drive_lamp_level;
            r_buzzer_level        <= n_buzzer_level;
        end
    end

    // Result register.
    logic [1:0]            r_out_state;
    logic                  r_out_brake_light;
    logic                  r_out_drive_lamp;
    logic                  r_out_buzzer;
    logic                  r_out_sent;
    logic [TORQUE_W-1:0]   r_out_cmd;
    logic                  r_out_fault;
    logic [DIFF_OUT_W-1:0] r_out_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_state       <= r_mode;
            r_out_brake_light <= brake_light;
            r_out_drive_lamp  <= n_drive_lamp_level;
            r_out_buzzer      <= n_buzzer_level;
            r_out_sent        <= sent;
            r_out_cmd         <= cmd;
            r_out_fault       <= r_mismatch_flag;
            r_out_diff        <= r_mismatch_flag ? r_last_difference : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_sent;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_diff, r_out_fault, r_out_cmd, r_out_buzzer,
                                      r_out_drive_lamp, r_out_brake_light, r_out_state});

    // A nonzero torque command only leaves the block for a tick taken in drive.
    a_torque_in_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_cmd != '0)) |-> (r_out_state == MODE_DRIVE))
        else $error("torque command outside drive");

    // The sequence never skips from init straight to buzzer or drive.
    a_init_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_INIT) |=> ((r_mode == MODE_INIT) || (r_mode == MODE_START)))
        else $error("illegal transition out of init");

    // Buzzer and drive lamp are never reported on together.
    a_lamp_buzzer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_buzzer && r_out_drive_lamp))
        else $error("buzzer and drive lamp both on");

    // A reported difference always comes with the fault flag.
    a_diff_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_diff != '0)) |-> r_out_fault)
        else $error("difference reported without fault");

endmodule

FILE: verif/tb_top.sv
module tb_top;
    import vde_pkg::*;

    // Packed width of the input tick, rounded up to whole bytes.
    localparam int IN_W = ((DEFAULT_TIME_BITS + 3 * DEFAULT_SAMPLE_BITS + 42 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETUP_MIN = 0;
    localparam int SETUP_MAX = 1;
    localparam int SETUP_RANDOM = 2;

    // One control tick as offered on the slave side.
    typedef struct {
        logic [31:0] now_ms;
        logic [9:0]  brake;
        logic [9:0]  pedal_high;
        logic [9:0]  pedal_low;
        logic        start;
        logic        frame_present;
        logic [28:0] frame_id;
        logic [3:0]  frame_len;
        logic [7:0]  frame_byte;
    } t_tick;

    // One status word as returned on the master side.
    typedef struct {
        logic [1:0]         state;
        logic               brake_light;
        logic               drive_lamp;
        logic               buzzer;
        logic               torque_sent;
        logic signed [15:0] torque_cmd;
        logic               fault;
        logic signed [11:0] diff;
    } t_status;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    // From bit 0: now_ms, brake, pedal high, pedal low, start, frame id, length, byte six.
    logic [IN_W-1:0]        i_s_tdata;
    // frame_present.
    logic                   i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // From bit 0: state, brake light, drive lamp, buzzer, torque, fault, diff.
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    // torque_sent.
    logic                   o_m_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    vehicle_drive_enable_fsm_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic [9:0]  press_level;
    logic [9:0]  lamp_threshold;
    logic [9:0]  mismatch_limit;
    logic [15:0] mismatch_hold_ms;
    logic [15:0] buzz_ms;
    logic        reverse_dir;
    logic [28:0] ready_id;
    logic [7:0]  ready_byte;

    // Shadow copy of the sequencer state.
    logic [1:0]         seq_mode;
    logic [31:0]        mode_since;
    logic               pedal_fault;
    logic [31:0]        fault_since;
    logic signed [11:0] fault_diff;
    logic               lamp_level;
    logic               buzz_level;

    t_status expected_status[$];
    t_status seen_status;
    t_status want_status;
    logic [31:0] stim_ms;
    int error_count;
    int ticks_sent;
    int results_checked;
    int drive_entries;
    int fault_trips;
    int cycle_count;
    int sink_hold_req;
    int sink_hold_left;
    bit sender_idle_on;
    bit sink_idle_on;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The run is cut off if it takes far longer than any correct run could.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_status.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Torque is the high pedal sample times 32, clipped before the direction is applied.
    function automatic logic signed [15:0] torque_for(logic [9:0] high);
        logic [31:0] mag;
        mag = 32'(high) * 32;
        if (mag > 32'd32767)
            mag = 32'd32767;
        return reverse_dir ? -$signed(mag[15:0]) : $signed(mag[15:0]);
    endfunction

    // Advances the shadow sequencer by one tick and returns the status it reports.
    function automatic t_status predict_status(t_tick t);
        t_status r;
        logic pressed;
        longint scaled, diff, lim;
        pressed = t.brake >= press_level;
        r.state = seq_mode;
        r.brake_light = t.brake >= lamp_threshold;
        r.fault = pedal_fault;
        r.diff = pedal_fault ? fault_diff : 12'sd0;
        r.torque_sent = 1'b1;
        r.torque_cmd = 16'sd0;
        case (seq_mode)
            MODE_INIT: begin
                lamp_level = 1'b0;
                buzz_level = 1'b0;
                if (t.start && pressed) begin
                    seq_mode = MODE_START;
                    mode_since = t.now_ms;
                end
            end
            MODE_START: begin
                // Releasing start or brake wins over any frame in the same tick.
                if (!t.start || !pressed) begin
                    seq_mode = MODE_INIT;
                    mode_since = t.now_ms;
                end else if (t.frame_present && t.frame_id == ready_id &&
                             t.frame_len >= READY_MIN_LEN && t.frame_byte == ready_byte) begin
                    seq_mode = MODE_BUZZ;
                    mode_since = t.now_ms;
                end
            end
            MODE_BUZZ: begin
                buzz_level = 1'b1;
                if (32'(t.now_ms - mode_since) >= 32'(buzz_ms)) begin
                    buzz_level = 1'b0;
                    seq_mode = MODE_DRIVE;
                    mode_since = t.now_ms;
                    lamp_level = 1'b1;
                    drive_entries++;
                end
            end
            default: begin
                scaled = (longint'(t.pedal_low) * 1023) / 675;
                diff = longint'(t.pedal_high) - scaled;
                lim = longint'(mismatch_limit);
                lamp_level = 1'b1;
                if (diff > 2047)
                    fault_diff = 12'sd2047;
                else if (diff < -2048)
                    fault_diff = -12'sd2048;
                else
                    fault_diff = 12'(diff);
                if (diff > lim || diff < -lim) begin
                    if (!pedal_fault) begin
                        // The first implausible tick only records the fault.
                        pedal_fault = 1'b1;
                        fault_since = t.now_ms;
                        r.torque_sent = 1'b0;
                    end else if (32'(t.now_ms - fault_since) >= 32'(mismatch_hold_ms)) begin
                        lamp_level = 1'b0;
                        seq_mode = MODE_INIT;
                        mode_since = t.now_ms;
                        fault_trips++;
                    end else begin
                        r.torque_cmd = torque_for(t.pedal_high);
                    end
                end else begin
                    pedal_fault = 1'b0;
                    r.torque_cmd = torque_for(t.pedal_high);
                end
            end
        endcase
        r.drive_lamp = lamp_level;
        r.buzzer = buzz_level;
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_tick(t_tick t);
        return {t.frame_byte, t.frame_len, t.frame_id, t.start,
                t.pedal_low, t.pedal_high, t.brake, t.now_ms};
    endfunction

    function automatic t_tick make_tick(logic [31:0] now, logic [9:0] brake, logic [9:0] high,
                                        logic [9:0] low, logic start, logic present,
                                        logic [28:0] id, logic [3:0] len, logic [7:0] data);
        t_tick t;
        t.now_ms = now;
        t.brake = brake;
        t.pedal_high = high;
        t.pedal_low = low;
        t.start = start;
        t.frame_present = present;
        t.frame_id = id;
        t.frame_len = len;
        t.frame_byte = data;
        return t;
    endfunction

    // Mostly short steps between ticks, with occasional long jumps and wraps.
    function automatic logic [31:0] time_step();
        int r;
        r = $urandom_range(99);
        if (r < 90)
            return $urandom_range(0, 25);
        else if (r < 98)
            return $urandom_range(0, 70000);
        return $urandom;
    endfunction

    function automatic logic [9:0] brake_for(bit held);
        if (held)
            return 10'($urandom_range(press_level, 1023));
        if (press_level == 10'd0)
            return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, press_level - 1));
    endfunction

    // Builds a tick that mostly moves the sequence forward from its current state.
    function automatic t_tick random_tick();
        t_tick t;
        int sc, hv;
        stim_ms = stim_ms + time_step();
        t.now_ms = stim_ms;
        t.brake = 10'($urandom_range(0, 1023));
        t.pedal_high = 10'($urandom_range(0, 1023));
        t.pedal_low = 10'($urandom_range(0, 1023));
        t.start = 1'($urandom_range(0, 1));
        t.frame_present = 1'($urandom_range(0, 1));
        t.frame_id = 29'($urandom);
        t.frame_len = 4'($urandom_range(0, 8));
        t.frame_byte = 8'($urandom);
        if ($urandom_range(99) < 85) begin
            case (seq_mode)
                MODE_INIT: begin
                    t.start = $urandom_range(9) != 0;
                    t.brake = brake_for($urandom_range(9) != 0);
                    t.frame_present = 1'b0;
                end
                MODE_START: begin
                    t.start = $urandom_range(19) != 0;
                    t.brake = brake_for($urandom_range(19) != 0);
                    t.frame_present = $urandom_range(99) < 30;
                    if ($urandom_range(4) != 0) begin
                        t.frame_id = ready_id;
                        t.frame_len = 4'($urandom_range(7, 8));
                        t.frame_byte = ready_byte;
                    end
                end
                MODE_DRIVE: begin
                    // Keep the two pedal readings within the allowed band most of the time.
                    if ($urandom_range(99) < 85) begin
                        sc = (int'(t.pedal_low) * 1023) / 675;
                        hv = sc + int'($urandom_range(0, 2 * mismatch_limit)) - int'(mismatch_limit);
                        if (hv < 0)
                            hv = 0;
                        if (hv > 1023)
                            hv = 1023;
                        t.pedal_high = 10'(hv);
                    end
                end
                default: begin
                end
            endcase
        end
        return t;
    endfunction

    // Offers one tick and records its expected status once the transfer happens.
    task automatic send_tick(input t_tick t);
        while (sender_idle_on && $urandom_range(99) < 7) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= pack_tick(t);
        i_s_tuser <= t.frame_present;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        expected_status.push_back(predict_status(t));
        ticks_sent++;
    endtask

    // Stops offering ticks and waits until every expected status has arrived.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one register; the caller lowers the valid after its last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [28:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_BRAKE_PRESS:  press_level = data[9:0];
            CFG_BRAKE_LAMP:   lamp_threshold = data[9:0];
            CFG_MISMATCH_LIM: mismatch_limit = data[9:0];
            CFG_MISMATCH_TMO: mismatch_hold_ms = data[15:0];
            CFG_BUZZ_DUR:     buzz_ms = data[15:0];
            CFG_REVERSE:      reverse_dir = data[0];
            CFG_READY_ID:     ready_id = data[28:0];
            CFG_READY_BYTE:   ready_byte = data[7:0];
            default: begin
            end
        endcase
    endtask

    // Picks a register value; bits above the register width carry random junk.
    function automatic logic [28:0] pick_value(int width, int flavor, int cap);
        logic [31:0] m, v;
        m = (32'd1 << width) - 1;
        if (flavor == SETUP_MIN)
            v = 32'd0;
        else if (flavor == SETUP_MAX)
            v = m;
        else if (cap > 0 && $urandom_range(9) < 7)
            v = $urandom_range(0, cap);
        else
            v = $urandom & m;
        return 29'(($urandom & ~m) | v);
    endfunction

    task automatic program_setup(input int flavor);
        write_reg(CFG_BRAKE_PRESS, pick_value(10, flavor, 0));
        write_reg(CFG_BRAKE_LAMP, pick_value(10, flavor, 0));
        write_reg(CFG_MISMATCH_LIM, pick_value(10, flavor, 0));
        write_reg(CFG_MISMATCH_TMO, pick_value(16, flavor, 80));
        write_reg(CFG_BUZZ_DUR, pick_value(16, flavor, 60));
        write_reg(CFG_REVERSE, pick_value(1, flavor, 0));
        write_reg(CFG_READY_ID, pick_value(29, flavor, 0));
        write_reg(CFG_READY_BYTE, pick_value(8, flavor, 0));
        i_cfg_valid <= 1'b0;
    endtask

    // Walks the whole sequence by hand, first at the reset settings.
    task automatic run_directed_sequence();
        logic [31:0] t0, t1, t2;
        t0 = 32'hFFFF_FF00;
        t1 = t0 + 10 + 2003;
        t2 = t1 + 200;
        send_tick(make_tick(32'd0, 10'd101, 10'd0, 10'd0, 1'b1, 1'b0, 29'd0, 4'd0, 8'd0));
        send_tick(make_tick(32'd1, 10'd599, 10'd0, 10'd0, 1'b1, 1'b0, 29'd0, 4'd0, 8'd0));
        send_tick(make_tick(t0, 10'd600, 10'd0, 10'd0, 1'b1, 1'b0, 29'd0, 4'd0, 8'd0));
        // Ready frames that are too short, carry the wrong byte or the wrong identifier.
        send_tick(make_tick(t0 + 1, 10'd700, 10'd0, 10'd0, 1'b1, 1'b1, RST_READY_ID, 4'd6,
                            RST_READY_BYTE));
        send_tick(make_tick(t0 + 2, 10'd700, 10'd0, 10'd0, 1'b1, 1'b1, RST_READY_ID, 4'd7,
                            8'hFF));
        send_tick(make_tick(t0 + 3, 10'd700, 10'd0, 10'd0, 1'b1, 1'b1, 29'h1FFF_FFFF, 4'd8,
                            RST_READY_BYTE));
        // Start released while a good frame arrives.
        send_tick(make_tick(t0 + 4, 10'd1023, 10'd0, 10'd0, 1'b0, 1'b1, RST_READY_ID, 4'd8,
                            RST_READY_BYTE));
        send_tick(make_tick(t0 + 5, 10'd1023, 10'd0, 10'd0, 1'b1, 1'b0, 29'd0, 4'd0, 8'd0));
        // A length code above eight still counts as long enough.
        send_tick(make_tick(t0 + 10, 10'd1023, 10'd0, 10'd0, 1'b1, 1'b1, RST_READY_ID, 4'd15,
                            RST_READY_BYTE));
        // The buzzer interval runs across the timestamp wrap.
        send_tick(make_tick(t0 + 10 + 1999, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 29'd0, 4'd0, 8'd0));
        send_tick(make_tick(t0 + 10 + 2000, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 29'd0, 4'd0, 8'd0));
        send_tick(make_tick(t0 + 10 + 2001, 10'd0, 10'd1023, 10'd675, 1'b0, 1'b0, 29'd0, 4'd0,
                            8'd0));
        send_tick(make_tick(t0 + 10 + 2002, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 29'd0, 4'd0, 8'd0));
        // First implausible tick, a held fault, then the timeout back to init.
        send_tick(make_tick(t1, 10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 29'd0, 4'd0, 8'd0));
        send_tick(make_tick(t1 + 50, 10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 29'd0, 4'd0, 8'd0));
        send_tick(make_tick(t1 + 100, 10'd0, 10'd0, 10'd1023, 1'b0, 1'b0, 29'd0, 4'd0, 8'd0));
        send_tick(make_tick(t1 + 101, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 29'd0, 4'd0, 8'd0));
        wait_drained();
        // Reversed torque, no buzzer wait, no fault tolerance.
        write_reg(CFG_REVERSE, 29'd1);
        write_reg(CFG_BUZZ_DUR, 29'd0);
        write_reg(CFG_MISMATCH_TMO, 29'd0);
        write_reg(CFG_MISMATCH_LIM, 29'd0);
        i_cfg_valid <= 1'b0;
        send_tick(make_tick(t2, 10'd1023, 10'd0, 10'd0, 1'b1, 1'b0, 29'd0, 4'd0, 8'd0));
        send_tick(make_tick(t2 + 1, 10'd1023, 10'd0, 10'd0, 1'b1, 1'b1, RST_READY_ID, 4'd7,
                            RST_READY_BYTE));
        send_tick(make_tick(t2 + 1, 10'd1023, 10'd0, 10'd0, 1'b1, 1'b0, 29'd0, 4'd0, 8'd0));
        // The fault kept from the last drive is cleared by a plausible tick.
        send_tick(make_tick(t2 + 2, 10'd0, 10'd674, 10'd445, 1'b0, 1'b0, 29'd0, 4'd0, 8'd0));
        send_tick(make_tick(t2 + 3, 10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 29'd0, 4'd0, 8'd0));
        send_tick(make_tick(t2 + 3, 10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 29'd0, 4'd0, 8'd0));
        stim_ms = t2 + 3;
        wait_drained();
    endtask

    // Random drive cycles under a fresh setting per phase, the extremes first.
    task automatic run_random_drive_cycles();
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            if (phase == 0)
                program_setup(SETUP_MIN);
            else if (phase == 1)
                program_setup(SETUP_MAX);
            else
                program_setup(SETUP_RANDOM);
            sender_idle_on = phase != 3;
            sink_idle_on = phase != 3;
            repeat (170) send_tick(random_tick());
        end
        sender_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // The sink holds off for a long stretch while ticks keep coming.
    task automatic run_backpressure();
        wait_drained();
        program_setup(SETUP_RANDOM);
        sink_hold_req = 300;
        sender_idle_on = 1'b0;
        repeat (80) send_tick(random_tick());
        sender_idle_on = 1'b1;
    endtask

    // The source stops until everything is out, then carries on.
    task automatic run_pause_and_drain();
        repeat (20) send_tick(random_tick());
        wait_drained();
        repeat (20) send_tick(random_tick());
    endtask

    // Sink side: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (sink_hold_req != 0) begin
            sink_hold_left = sink_hold_req;
            sink_hold_req = 0;
        end
        if (sink_hold_left > 0) begin
            i_m_tready <= 1'b0;
            sink_hold_left--;
        end else begin
            i_m_tready <= !(sink_idle_on && $urandom_range(99) < 7);
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Each status transfer is compared with the oldest expected status.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_status.size() == 0) begin
                $error("status transfer with no expected status waiting");
                error_count++;
            end else begin
                want_status = expected_status.pop_front();
                seen_status.state = o_m_tdata[1:0];
                seen_status.brake_light = o_m_tdata[2];
                seen_status.drive_lamp = o_m_tdata[3];
                seen_status.buzzer = o_m_tdata[4];
                seen_status.torque_cmd = o_m_tdata[20:5];
                seen_status.fault = o_m_tdata[21];
                seen_status.diff = o_m_tdata[33:22];
                seen_status.torque_sent = o_m_tuser;
                check_field("vehicle_state", want_status.state, seen_status.state);
                check_field("brake_light", want_status.brake_light, seen_status.brake_light);
                check_field("drive_lamp", want_status.drive_lamp, seen_status.drive_lamp);
                check_field("buzzer_on", want_status.buzzer, seen_status.buzzer);
                check_field("torque_sent", want_status.torque_sent, seen_status.torque_sent);
                check_field("torque_cmd", want_status.torque_cmd, seen_status.torque_cmd);
                check_field("fault_reported", want_status.fault, seen_status.fault);
                check_field("diff_reported", want_status.diff, seen_status.diff);
                results_checked++;
            end
        end
    end

    // Test sequence.
    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        press_level = RST_BRAKE_PRESS;
        lamp_threshold = RST_BRAKE_LAMP;
        mismatch_limit = RST_MISMATCH_LIM;
        mismatch_hold_ms = RST_MISMATCH_TMO;
        buzz_ms = RST_BUZZ_DUR;
        reverse_dir = 1'b0;
        ready_id = RST_READY_ID;
        ready_byte = RST_READY_BYTE;
        seq_mode = MODE_INIT;
        mode_since = '0;
        pedal_fault = 1'b0;
        fault_since = '0;
        fault_diff = '0;
        lamp_level = 1'b0;
        buzz_level = 1'b0;
        stim_ms = '0;
        error_count = 0;
        ticks_sent = 0;
        results_checked = 0;
        drive_entries = 0;
        fault_trips = 0;
        cycle_count = 0;
        sink_hold_req = 0;
        sink_hold_left = 0;
        sender_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed_sequence();
        run_random_drive_cycles();
        run_backpressure();
        run_pause_and_drain();
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d ticks and checked %0d status words over directed, random,",
                 ticks_sent, results_checked);
        $display("stall and drain phases; drive entered %0d times, %0d pedal fault timeouts.",
                 drive_entries, fault_trips);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
